// File: rtl/core/bcr_pkg.sv
// Shared types and constants of the block cache replacement controller.
package bcr_pkg;

    localparam int BLOCK_BITS  = 16;
    localparam int SLOT_BITS   = 4;
    localparam int POLICY_BITS = 2;

    // Replacement policy codes; the unused code behaves as list order.
    localparam logic [POLICY_BITS-1:0] POLICY_FIFO = 2'd0;
    localparam logic [POLICY_BITS-1:0] POLICY_LRU  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POLICY_LFU  = 2'd2;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [BLOCK_BITS-1:0] block_number;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_BITS-1:0]  slot;
        logic                  evicted;
        logic [BLOCK_BITS-1:0] evicted_block;
        logic                  writeback;
    } rsp_t;

    // Command broadcast from the controller to every entry cell.
    typedef struct packed {
        logic apply;
        logic is_hit;
        logic is_write;
        logic age_all;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_UPDATE
    } bcr_state_t;

endpackage

// File: rtl/core/bcr_cell.sv
// One cache entry: tag, flags, use count, recency rank and one stage of the victim chain.
module bcr_cell #(
    parameter int ENTRIES    = 16,
    parameter int INDEX      = 0,
    parameter int TAG_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [TAG_BITS-1:0]         lookup_tag,
    input  logic [TAG_BITS-1:0]         fill_tag,
    input  bcr_pkg::cell_cmd_t          cmd,
    input  logic                        sel,
    input  logic [$clog2(ENTRIES)-1:0]  limit,
    input  logic [COUNT_BITS-1:0]       chain_count_in,
    input  logic [$clog2(ENTRIES)-1:0]  chain_rank_in,
    input  logic [$clog2(ENTRIES)-1:0]  chain_idx_in,
    output logic [COUNT_BITS-1:0]       chain_count_out,
    output logic [$clog2(ENTRIES)-1:0]  chain_rank_out,
    output logic [$clog2(ENTRIES)-1:0]  chain_idx_out,
    output logic                        valid,
    output logic                        match,
    output logic                        oldest,
    output logic [TAG_BITS-1:0]         sel_tag,
    output logic [$clog2(ENTRIES)-1:0]  sel_rank,
    output logic                        sel_dirty
);
    import bcr_pkg::*;

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam logic [IDX_BITS-1:0] MY_INDEX  = IDX_BITS'(INDEX);
    localparam logic [IDX_BITS-1:0] RANK_LAST = IDX_BITS'(ENTRIES - 1);

    logic                  valid_reg, valid_next;
    logic                  dirty_reg, dirty_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [IDX_BITS-1:0]   rank_reg, rank_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;

    logic [COUNT_BITS-1:0] chain_count_reg, chain_count_next;
    logic [IDX_BITS-1:0]   chain_rank_reg, chain_rank_next;
    logic [IDX_BITS-1:0]   chain_idx_reg, chain_idx_next;
    logic                  take_own;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        tag_next   = tag_reg;
        if (cmd.apply)
        begin
            if (sel)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                if (cmd.is_hit)
                begin
                    dirty_next = dirty_reg | cmd.is_write;
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    dirty_next = 1'b0;
                    count_next = '0;
                    tag_next   = fill_tag;
                end
            end
            else if (valid_reg && (cmd.age_all || rank_reg < limit))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    // The chain keeps the entry with the lowest (use count, rank) pair seen so far.
    always_comb
    begin
        take_own = (INDEX == 0) || (count_reg < chain_count_in) ||
                   (count_reg == chain_count_in && rank_reg < chain_rank_in);
        if (take_own)
        begin
            chain_count_next = count_reg;
            chain_rank_next  = rank_reg;
            chain_idx_next   = MY_INDEX;
        end
        else
        begin
            chain_count_next = chain_count_in;
            chain_rank_next  = chain_rank_in;
            chain_idx_next   = chain_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            count_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg         <= tag_next;
        chain_count_reg <= chain_count_next;
        chain_rank_reg  <= chain_rank_next;
        chain_idx_reg   <= chain_idx_next;
    end

    assign valid           = valid_reg;
    assign match           = valid_reg && (tag_reg == lookup_tag);
    assign oldest          = valid_reg && (rank_reg == RANK_LAST);
    assign sel_tag         = sel ? tag_reg : '0;
    assign sel_rank        = sel ? rank_reg : '0;
    assign sel_dirty       = sel & dirty_reg;
    assign chain_count_out = chain_count_reg;
    assign chain_rank_out  = chain_rank_reg;
    assign chain_idx_out   = chain_idx_reg;

endmodule

// File: rtl/core/block_cache_replacement.sv
// Top level of the block cache replacement controller: access control and the row of entry cells.
//
// Tag and replacement controller of a fully associative cache of CACHE_ENTRIES blocks. Each
// request transfer carries an access kind and a block number; exactly one response transfer
// follows, giving hit, the slot that now holds the block and, on a miss into a full cache, the
// evicted block and whether it must be written back. The request is compared against every
// entry cell in the cycle of its transfer, and the whole row of cells is updated in the update
// state once the output register can take the response, which is loaded in that update. Least
// frequently used eviction (policy 2) instead takes its victim from a chain that passes the best
// candidate one cell per cycle along the row; such an eviction waits until the cells have stood
// still for a full pass of the chain, so that the chain holds a valid answer. A new request is
// taken only once the previous access has updated the cells, while its response may still be
// waiting in the output register. The policy register is written through the configuration
// channel, which is always ready, and should only be written while no access is in progress.
// No clearing pass runs after reset.
module block_cache_replacement #(
    parameter int CACHE_ENTRIES      = 16,
    parameter int BLOCK_ADDRESS_BITS = 16,
    parameter int COUNT_BITS         = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcr_pkg::POLICY_BITS-1:0]      cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  bcr_pkg::req_t                        req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output bcr_pkg::rsp_t                        rsp
);
    import bcr_pkg::*;

    localparam int IDX_BITS  = $clog2(CACHE_ENTRIES);
    localparam int FILL_BITS = $clog2(CACHE_ENTRIES + 1);
    localparam int TAG_BITS  = (BLOCK_ADDRESS_BITS < BLOCK_BITS) ? BLOCK_ADDRESS_BITS
                                                                  : BLOCK_BITS;
    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(CACHE_ENTRIES);

    // Control state.
    bcr_state_t             state_reg, state_next;
    logic [POLICY_BITS-1:0] policy_reg, policy_next;
    logic [FILL_BITS-1:0]   fill_count_reg, fill_count_next;
    logic [FILL_BITS-1:0]   settle_cnt_reg, settle_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // Access held between the lookup and the update.
    logic                     hit_reg, hit_next;
    logic                     evict_reg, evict_next;
    logic                     write_reg, write_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;
    logic [CACHE_ENTRIES-1:0] sel_reg, sel_next;
    rsp_t                     rsp_reg, rsp_next;

    // Row signals.
    logic [TAG_BITS-1:0]      lookup_tag;
    logic [CACHE_ENTRIES-1:0] match_vec, valid_vec, oldest_vec, fill_vec, lfu_vec, sel_vec;
    logic [TAG_BITS-1:0]      sel_tag_vec [CACHE_ENTRIES];
    logic [IDX_BITS-1:0]      sel_rank_vec [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] sel_dirty_vec;
    logic [COUNT_BITS-1:0]    chain_count_out [CACHE_ENTRIES];
    logic [IDX_BITS-1:0]      chain_rank_out [CACHE_ENTRIES];
    logic [IDX_BITS-1:0]      chain_idx_out [CACHE_ENTRIES];
    logic [COUNT_BITS-1:0]    chain_count_in [CACHE_ENTRIES];
    logic [IDX_BITS-1:0]      chain_rank_in [CACHE_ENTRIES];
    logic [IDX_BITS-1:0]      chain_idx_in [CACHE_ENTRIES];

    logic [TAG_BITS-1:0]      sel_tag;
    logic [IDX_BITS-1:0]      sel_rank;
    logic                     sel_dirty;
    logic [IDX_BITS-1:0]      slot_idx;
    logic                     hit_any, full, is_lfu, settled, can_load;
    cell_cmd_t                cmd;

    assign lookup_tag = TAG_BITS'(req.block_number);
    assign full       = (fill_count_reg == FILL_FULL);
    assign is_lfu     = (policy_reg == POLICY_LFU);
    assign settled    = (settle_cnt_reg == FILL_FULL);
    assign hit_any    = |match_vec;
    assign can_load   = !rsp_valid_reg || rsp_ready;

    // The first cell starts the chain; every other cell takes its left neighbour's candidate.
    always_comb
    begin
        for (int k = 0; k < CACHE_ENTRIES; k++)
        begin
            if (k == 0)
            begin
                chain_count_in[k] = '0;
                chain_rank_in[k]  = '0;
                chain_idx_in[k]   = '0;
            end
            else
            begin
                chain_count_in[k] = chain_count_out[k-1];
                chain_rank_in[k]  = chain_rank_out[k-1];
                chain_idx_in[k]   = chain_idx_out[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CACHE_ENTRIES; g++)
        begin : g_cell
            bcr_cell #(
                .ENTRIES    (CACHE_ENTRIES),
                .INDEX      (g),
                .TAG_BITS   (TAG_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .lookup_tag      (lookup_tag),
                .fill_tag        (tag_reg),
                .cmd             (cmd),
                .sel             (sel_vec[g]),
                .limit           (sel_rank),
                .chain_count_in  (chain_count_in[g]),
                .chain_rank_in   (chain_rank_in[g]),
                .chain_idx_in    (chain_idx_in[g]),
                .chain_count_out (chain_count_out[g]),
                .chain_rank_out  (chain_rank_out[g]),
                .chain_idx_out   (chain_idx_out[g]),
                .valid           (valid_vec[g]),
                .match           (match_vec[g]),
                .oldest          (oldest_vec[g]),
                .sel_tag         (sel_tag_vec[g]),
                .sel_rank        (sel_rank_vec[g]),
                .sel_dirty       (sel_dirty_vec[g])
            );
        end
    endgenerate

    // Slot selection. Free slots fill in order, so the lowest free slot is the fill count.
    // List order and least recent both evict the entry of the highest rank; least frequent
    // takes the index that has come out at the end of the chain.
    always_comb
    begin
        for (int k = 0; k < CACHE_ENTRIES; k++)
        begin
            fill_vec[k] = (fill_count_reg == FILL_BITS'(k));
            lfu_vec[k]  = (chain_idx_out[CACHE_ENTRIES-1] == IDX_BITS'(k));
        end
        if (evict_reg)
        begin
            sel_vec = is_lfu ? lfu_vec : oldest_vec;
        end
        else
        begin
            sel_vec = sel_reg;
        end
    end

    // Read back the selected entry by an OR over the gated cell outputs.
    always_comb
    begin
        sel_tag   = '0;
        sel_rank  = '0;
        slot_idx  = '0;
        sel_dirty = |sel_dirty_vec;
        for (int k = 0; k < CACHE_ENTRIES; k++)
        begin
            sel_tag  = sel_tag | sel_tag_vec[k];
            sel_rank = sel_rank | sel_rank_vec[k];
            if (sel_vec[k])
            begin
                slot_idx = slot_idx | IDX_BITS'(k);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        hit_next        = hit_reg;
        evict_next      = evict_reg;
        write_next      = write_reg;
        tag_next        = tag_reg;
        sel_next        = sel_reg;
        rsp_next        = rsp_reg;
        req_ready       = 1'b0;
        cmd             = '0;
        cmd.is_hit      = hit_reg;
        cmd.is_write    = write_reg;
        cmd.age_all     = !hit_reg && !evict_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    hit_next   = hit_any;
                    evict_next = !hit_any && full;
                    write_next = (req.operation == OP_WRITE);
                    tag_next   = lookup_tag;
                    sel_next   = hit_any ? match_vec : fill_vec;
                    if (!hit_any && full && is_lfu && !settled)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_WAIT:
            begin
                if (settled)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (can_load)
                begin
                    cmd.apply              = 1'b1;
                    rsp_valid_next         = 1'b1;
                    rsp_next.hit           = hit_reg;
                    rsp_next.slot          = SLOT_BITS'(slot_idx);
                    rsp_next.evicted       = evict_reg;
                    rsp_next.evicted_block = evict_reg ? BLOCK_BITS'(sel_tag) : '0;
                    rsp_next.writeback     = evict_reg && sel_dirty;
                    if (!hit_reg && !evict_reg)
                    begin
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The chain answer is trusted once the cells have stood still for a full pass.
    always_comb
    begin
        if (cmd.apply)
        begin
            settle_cnt_next = '0;
        end
        else if (settled)
        begin
            settle_cnt_next = settle_cnt_reg;
        end
        else
        begin
            settle_cnt_next = settle_cnt_reg + 1'b1;
        end
    end

    assign policy_next = cfg_valid ? cfg_data : policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            policy_reg     <= POLICY_FIFO;
            fill_count_reg <= '0;
            settle_cnt_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            fill_count_reg <= fill_count_next;
            settle_cnt_reg <= settle_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        evict_reg <= evict_next;
        write_reg <= write_next;
        tag_reg   <= tag_next;
        sel_reg   <= sel_next;
        rsp_reg   <= rsp_next;
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // Slots fill in order and are never freed, so the fill count tracks the valid entries.
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_count_reg))
        else $error("fill count disagrees with the valid entries");

    // Every update acts on exactly one entry.
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> $onehot(sel_vec))
        else $error("update without a single selected entry");

    // Eviction only happens in a full cache.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && evict_reg) |-> full)
        else $error("eviction while a slot is free");

    // Waiting for the chain only makes sense for an eviction.
    a_wait_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> (evict_reg && !hit_reg))
        else $error("chain wait without an eviction");

    // Each update leaves a response in the output register.
    a_update_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> rsp_valid_reg)
        else $error("update without a response");
`endif

endmodule
